/* hw/rtl/site_pattern_dedup_counter_top_assert.svh */
// Assertion macros shared by the site pattern dedup counter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SITE_PATTERN_DEDUP_COUNTER_TOP_ASSERT_SVH
`define SITE_PATTERN_DEDUP_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SPDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SPDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/spdc_pkg.sv */
// Shared types and constants of the site pattern dedup counter.
// No dependencies; used by controller, datapath and top level.
package spdc_pkg;

    localparam int SYMBOL_W    = 4;
    localparam int IDX_OUT_W   = 6;
    localparam int COUNT_OUT_W = 24;
    localparam int TOTAL_OUT_W = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;

    localparam logic [SYMBOL_W-1:0] GAP_CODE = 4'd4;

    typedef enum logic [1:0] {
        STATUS_MATCH = 2'd0,
        STATUS_NEW   = 2'd1,
        STATUS_GAP   = 2'd2,
        STATUS_FULL  = 2'd3
    } col_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_ROW_RD,
        ST_ROW_CHK,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_ALLOC,
        ST_OUT
    } spdc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic col_accept;
        logic scan_start;
        logic slot_next;
        logic row_start;
        logic row_next;
        logic res_match;
        logic res_new;
        logic res_full;
        logic res_gap;
    } spdc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic gap_drop;
        logic scan_done;
        logic len_eq;
        logic row_eq;
        logic row_last;
        logic room;
    } spdc_sts_t;

endpackage

/* hw/rtl/spdc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/spdc_ctrl.sv */
// Controller state machine of the site pattern dedup counter.
// Depends on spdc_pkg and the assertion macro header.
`include "site_pattern_dedup_counter_top_assert.svh"

module spdc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  spdc_pkg::spdc_sts_t sts,
    output spdc_pkg::spdc_cmd_t cmd
);

    spdc_pkg::spdc_state_t state_reg;
    spdc_pkg::spdc_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spdc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spdc_pkg::ST_IDLE: begin
                if (s_tvalid && s_tlast) begin
                    state_next = spdc_pkg::ST_CHECK;
                end
            end
            spdc_pkg::ST_CHECK: begin
                state_next = sts.gap_drop ? spdc_pkg::ST_OUT : spdc_pkg::ST_LEN_RD;
            end
            spdc_pkg::ST_LEN_RD: begin
                state_next = sts.scan_done ? spdc_pkg::ST_ALLOC : spdc_pkg::ST_LEN_CHK;
            end
            spdc_pkg::ST_LEN_CHK: begin
                state_next = sts.len_eq ? spdc_pkg::ST_ROW_RD : spdc_pkg::ST_LEN_RD;
            end
            spdc_pkg::ST_ROW_RD: begin
                state_next = spdc_pkg::ST_ROW_CHK;
            end
            spdc_pkg::ST_ROW_CHK: begin
                if (!sts.row_eq) begin
                    state_next = spdc_pkg::ST_LEN_RD;
                end else if (sts.row_last) begin
                    state_next = spdc_pkg::ST_CNT_RD;
                end else begin
                    state_next = spdc_pkg::ST_ROW_RD;
                end
            end
            spdc_pkg::ST_CNT_RD: begin
                state_next = spdc_pkg::ST_CNT_WR;
            end
            spdc_pkg::ST_CNT_WR: begin
                state_next = spdc_pkg::ST_OUT;
            end
            spdc_pkg::ST_ALLOC: begin
                state_next = spdc_pkg::ST_OUT;
            end
            spdc_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = spdc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spdc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            spdc_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.col_accept = s_tvalid;
            end
            spdc_pkg::ST_CHECK: begin
                cmd.res_gap    = sts.gap_drop;
                cmd.scan_start = !sts.gap_drop;
            end
            spdc_pkg::ST_LEN_CHK: begin
                cmd.row_start = sts.len_eq;
                cmd.slot_next = !sts.len_eq;
            end
            spdc_pkg::ST_ROW_CHK: begin
                cmd.slot_next = !sts.row_eq;
                cmd.row_next  = sts.row_eq && !sts.row_last;
            end
            spdc_pkg::ST_CNT_WR: begin
                cmd.res_match = 1'b1;
            end
            spdc_pkg::ST_ALLOC: begin
                cmd.res_new  = sts.room;
                cmd.res_full = !sts.room;
            end
            spdc_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // checks
    `SPDC_ASSERT_SAME(a_one_side, aclk, aresetn, m_tvalid, !s_tready, "both channels open")
    `SPDC_ASSERT_NEXT(a_last_scans, aclk, aresetn, s_tvalid && s_tready && s_tlast,
        state_reg == spdc_pkg::ST_CHECK, "last row did not start the column check")
    `SPDC_ASSERT_SAME(a_one_result, aclk, aresetn, 1'b1,
        $countones({cmd.res_match, cmd.res_new, cmd.res_full, cmd.res_gap}) <= 1,
        "several result kinds at once")

endmodule

/* hw/rtl/spdc_dpath.sv */
// Datapath of the site pattern dedup counter: column buffer, pattern store,
// length and count memories, scan counters and result registers.
// Depends on spdc_pkg, spdc_ram and the assertion macro header.
`include "site_pattern_dedup_counter_top_assert.svh"

module spdc_dpath #(
    parameter int MAX_ROWS     = 32,
    parameter int MAX_PATTERNS = 64,
    parameter int COUNT_BITS   = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic [spdc_pkg::SYMBOL_W-1:0]     symbol,
    input  spdc_pkg::spdc_cmd_t               cmd,
    output spdc_pkg::spdc_sts_t               sts,
    output logic [spdc_pkg::IDX_OUT_W-1:0]    pattern_index,
    output spdc_pkg::col_status_t             column_status,
    output logic [spdc_pkg::COUNT_OUT_W-1:0]  pattern_count,
    output logic [spdc_pkg::TOTAL_OUT_W-1:0]  unique_total
);

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int LEN_W    = $clog2(MAX_ROWS + 1);
    localparam int SLOT_W   = $clog2(MAX_PATTERNS);
    localparam int TOT_W    = $clog2(MAX_PATTERNS + 1);
    localparam int ROW_SPAN = 2 ** ROW_W;
    localparam int STORE_D  = MAX_PATTERNS * ROW_SPAN;

    logic                  keep_reg;
    logic [LEN_W-1:0]      row_pos_reg;
    logic                  gap_reg;
    logic [TOT_W-1:0]      total_reg;
    logic [TOT_W-1:0]      slot_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [SLOT_W-1:0]     res_idx_reg;
    spdc_pkg::col_status_t res_status_reg;
    logic [COUNT_BITS-1:0] res_cnt_reg;

    logic                  row_room;
    logic                  table_room;
    logic [SLOT_W-1:0]     slot_idx;
    logic [SLOT_W-1:0]     total_idx;
    logic [ROW_W-1:0]      row_wr;

    logic [spdc_pkg::SYMBOL_W-1:0] col_rd;
    logic [spdc_pkg::SYMBOL_W-1:0] store_rd;
    logic [LEN_W-1:0]              len_rd;
    logic [COUNT_BITS-1:0]         cnt_rd;
    logic [COUNT_BITS-1:0]         cnt_inc;
    logic                          cnt_we;
    logic [SLOT_W-1:0]             cnt_waddr;
    logic [COUNT_BITS-1:0]         cnt_wdata;

    assign row_room   = row_pos_reg < LEN_W'(MAX_ROWS);
    assign table_room = total_reg < TOT_W'(MAX_PATTERNS);
    assign slot_idx   = slot_reg[SLOT_W-1:0];
    assign total_idx  = total_reg[SLOT_W-1:0];
    assign row_wr     = row_pos_reg[ROW_W-1:0];

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            keep_reg <= cfg_wr_data;
        end
    end

    // column buffer: rows of the column now arriving
    spdc_ram #(.WIDTH(spdc_pkg::SYMBOL_W), .DEPTH(ROW_SPAN)) u_col_ram (
        .aclk  (aclk),
        .we    (cmd.col_accept && row_room),
        .waddr (row_wr),
        .wdata (symbol),
        .raddr (row_reg),
        .rdata (col_rd)
    );

    // pattern store, written straight into the next free slot
    spdc_ram #(.WIDTH(spdc_pkg::SYMBOL_W), .DEPTH(STORE_D)) u_store_ram (
        .aclk  (aclk),
        .we    (cmd.col_accept && row_room && table_room),
        .waddr ({total_idx, row_wr}),
        .wdata (symbol),
        .raddr ({slot_idx, row_reg}),
        .rdata (store_rd)
    );

    // pattern lengths
    spdc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERNS)) u_len_ram (
        .aclk  (aclk),
        .we    (cmd.res_new),
        .waddr (total_idx),
        .wdata (row_pos_reg),
        .raddr (slot_idx),
        .rdata (len_rd)
    );

    // occurrence counts, saturating increment on a match
    assign cnt_inc   = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
    assign cnt_we    = cmd.res_new || cmd.res_match;
    assign cnt_waddr = cmd.res_new ? total_idx : slot_idx;
    assign cnt_wdata = cmd.res_new ? COUNT_BITS'(1) : cnt_inc;

    spdc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_PATTERNS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (slot_idx),
        .rdata (cnt_rd)
    );

    // column tracking and pattern total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            gap_reg     <= 1'b0;
            total_reg   <= '0;
        end else begin
            if (cmd.col_accept) begin
                if (symbol == spdc_pkg::GAP_CODE) begin
                    gap_reg <= 1'b1;
                end
                if (row_room) begin
                    row_pos_reg <= row_pos_reg + LEN_W'(1);
                end
            end
            if (cmd.res_match || cmd.res_new || cmd.res_full || cmd.res_gap) begin
                row_pos_reg <= '0;
                gap_reg     <= 1'b0;
            end
            if (cmd.res_new) begin
                total_reg <= total_reg + TOT_W'(1);
            end
        end
    end

    // scan counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            row_reg  <= '0;
        end else begin
            if (cmd.scan_start) begin
                slot_reg <= '0;
            end else if (cmd.slot_next) begin
                slot_reg <= slot_reg + TOT_W'(1);
            end
            if (cmd.row_start) begin
                row_reg <= '0;
            end else if (cmd.row_next) begin
                row_reg <= row_reg + ROW_W'(1);
            end
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.res_match) begin
            res_idx_reg    <= slot_idx;
            res_status_reg <= spdc_pkg::STATUS_MATCH;
            res_cnt_reg    <= cnt_inc;
        end else if (cmd.res_new) begin
            res_idx_reg    <= total_idx;
            res_status_reg <= spdc_pkg::STATUS_NEW;
            res_cnt_reg    <= COUNT_BITS'(1);
        end else if (cmd.res_full) begin
            res_idx_reg    <= '0;
            res_status_reg <= spdc_pkg::STATUS_FULL;
            res_cnt_reg    <= '0;
        end else if (cmd.res_gap) begin
            res_idx_reg    <= '0;
            res_status_reg <= spdc_pkg::STATUS_GAP;
            res_cnt_reg    <= '0;
        end
    end

    // status to controller
    assign sts.gap_drop  = gap_reg && !keep_reg;
    assign sts.scan_done = slot_reg == total_reg;
    assign sts.len_eq    = len_rd == row_pos_reg;
    assign sts.row_eq    = store_rd == col_rd;
    assign sts.row_last  = LEN_W'(row_reg) == (row_pos_reg - LEN_W'(1));
    assign sts.room      = table_room;

    // fixed-width result fields, low bits shown
    logic [SLOT_W+spdc_pkg::IDX_OUT_W-1:0]       idx_wide;
    logic [COUNT_BITS+spdc_pkg::COUNT_OUT_W-1:0] cnt_wide;
    logic [TOT_W+spdc_pkg::TOTAL_OUT_W-1:0]      tot_wide;

    assign idx_wide      = {{spdc_pkg::IDX_OUT_W{1'b0}}, res_idx_reg};
    assign cnt_wide      = {{spdc_pkg::COUNT_OUT_W{1'b0}}, res_cnt_reg};
    assign tot_wide      = {{spdc_pkg::TOTAL_OUT_W{1'b0}}, total_reg};
    assign pattern_index = idx_wide[spdc_pkg::IDX_OUT_W-1:0];
    assign pattern_count = cnt_wide[spdc_pkg::COUNT_OUT_W-1:0];
    assign unique_total  = tot_wide[spdc_pkg::TOTAL_OUT_W-1:0];
    assign column_status = res_status_reg;

    // checks
    `SPDC_ASSERT_SAME(a_total_bound, aclk, aresetn, 1'b1,
        total_reg <= TOT_W'(MAX_PATTERNS), "pattern total past table size")
    `SPDC_ASSERT_NEXT(a_new_grows, aclk, aresetn, cmd.res_new,
        total_reg == $past(total_reg) + TOT_W'(1), "new pattern did not raise the total")
    `SPDC_ASSERT_SAME(a_scan_bound, aclk, aresetn, 1'b1,
        slot_reg <= total_reg, "scan slot past the pattern total")

endmodule

/* hw/rtl/site_pattern_dedup_counter_top.sv */
// Top level of the site pattern dedup counter: stream ports and config bit.
// Depends on spdc_pkg, spdc_ctrl and spdc_dpath.
//
//  channel   | direction | tdata / tuser             | tlast
//  s_ (rows) | in        | symbol / -                | last row of column
//  m_ (cols) | out       | index,count,total / status| -
//  cfg       | in        | keep_gapped_columns       | -
//
// A row that is not the last of its column is taken while idle. The last row
// starts a scan of the stored patterns through the single read port of each
// memory: a length read and check per stored pattern, a read and compare per
// row of a pattern of equal length, then the count update or allocation and
// the output state. A gapped column dropped by the config bit goes from the
// check state to output. No rows are taken while a result waits on m_tready.
// Synchronous reset; no clearing pass, memories are read only where written.
module site_pattern_dedup_counter_top #(
    parameter int MAX_ROWS     = 32,
    parameter int MAX_PATTERNS = 64,
    parameter int COUNT_BITS   = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spdc_pkg::S_TDATA_W-1:0]   s_tdata,  // [3:0] symbol, [7:4] zero
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [5:0] pattern_index, [29:6] pattern_count, [36:30] unique_total, [39:37] zero
    output logic [spdc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [spdc_pkg::M_TUSER_W-1:0]   m_tuser   // [1:0] column_status
);

    spdc_pkg::spdc_cmd_t cmd;
    spdc_pkg::spdc_sts_t sts;

    logic [spdc_pkg::IDX_OUT_W-1:0]   pattern_index;
    spdc_pkg::col_status_t            column_status;
    logic [spdc_pkg::COUNT_OUT_W-1:0] pattern_count;
    logic [spdc_pkg::TOTAL_OUT_W-1:0] unique_total;

    spdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spdc_dpath #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_PATTERNS (MAX_PATTERNS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .symbol        (s_tdata[spdc_pkg::SYMBOL_W-1:0]),
        .cmd           (cmd),
        .sts           (sts),
        .pattern_index (pattern_index),
        .column_status (column_status),
        .pattern_count (pattern_count),
        .unique_total  (unique_total)
    );

    // pack the result transaction
    assign m_tdata = {3'b000, unique_total, pattern_count, pattern_index};
    assign m_tuser = column_status;

endmodule

/* test/spdc_column_checker.sv */
// Column outcome checker for the site pattern dedup counter.
// Depends on spdc_pkg; watches the row, result and config ports of the block.
module spdc_column_checker #(
    parameter int MAX_ROWS     = 32,
    parameter int MAX_PATTERNS = 64,
    parameter int COUNT_BITS   = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [spdc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [spdc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [spdc_pkg::M_TUSER_W-1:0] m_tuser,
    output int unsigned                    failures,
    output int unsigned                    columns_open
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_SLOT = MAX_PATTERNS;

    typedef struct packed {
        logic [spdc_pkg::TOTAL_OUT_W-1:0] total;
        logic [spdc_pkg::COUNT_OUT_W-1:0] count;
        spdc_pkg::col_status_t            status;
        logic [spdc_pkg::IDX_OUT_W-1:0]   slot;
    } column_outcome_t;

    // Pattern table as the block should hold it
    logic [spdc_pkg::SYMBOL_W-1:0] pattern_lib [MAX_PATTERNS][MAX_ROWS];
    int unsigned                   library_len [MAX_PATTERNS];
    logic [COUNT_BITS-1:0]         tally [MAX_PATTERNS];
    int unsigned                   library_size;

    // Column being received
    logic [spdc_pkg::SYMBOL_W-1:0] column_buf [MAX_ROWS];
    int unsigned                   rows_in;
    logic                          gap_in_column;
    logic                          keep_gapped;

    column_outcome_t       predicted_outcomes[$];
    int unsigned           mismatch_count = 0;

    initial begin
        failures     = 0;
        columns_open = 0;
    end

    // Fold one row into the column; on the last row settle the outcome
    task automatic fold_row(input logic [spdc_pkg::SYMBOL_W-1:0] sym, input logic last);
        int unsigned     s;
        int unsigned     r;
        int unsigned     hit;
        logic            same;
        column_outcome_t res;
        if (sym == spdc_pkg::GAP_CODE)
            gap_in_column = 1'b1;
        // rows past the table depth only matter for the gap check
        if (rows_in < MAX_ROWS) begin
            column_buf[rows_in] = sym;
            rows_in++;
        end
        if (last) begin
            res = '0;
            hit = NO_SLOT;
            if (gap_in_column && !keep_gapped) begin
                res.status = spdc_pkg::STATUS_GAP;
            end else begin
                for (s = 0; s < library_size && hit == NO_SLOT; s++) begin
                    if (library_len[s] == rows_in) begin
                        same = 1'b1;
                        for (r = 0; r < rows_in; r++)
                            if (pattern_lib[s][r] != column_buf[r])
                                same = 1'b0;
                        if (same)
                            hit = s;
                    end
                end
                if (hit != NO_SLOT) begin
                    if (tally[hit] != {COUNT_BITS{1'b1}})
                        tally[hit] = tally[hit] + 1'b1;
                    res.slot   = spdc_pkg::IDX_OUT_W'(hit);
                    res.count  = spdc_pkg::COUNT_OUT_W'(tally[hit]);
                    res.status = spdc_pkg::STATUS_MATCH;
                end else if (library_size < MAX_PATTERNS) begin
                    for (r = 0; r < rows_in; r++)
                        pattern_lib[library_size][r] = column_buf[r];
                    library_len[library_size] = rows_in;
                    tally[library_size]       = COUNT_BITS'(1);
                    res.slot   = spdc_pkg::IDX_OUT_W'(library_size);
                    res.count  = spdc_pkg::COUNT_OUT_W'(1);
                    res.status = spdc_pkg::STATUS_NEW;
                    library_size++;
                end else begin
                    res.status = spdc_pkg::STATUS_FULL;
                end
            end
            res.total = spdc_pkg::TOTAL_OUT_W'(library_size);
            predicted_outcomes.push_back(res);
            rows_in       = 0;
            gap_in_column = 1'b0;
        end
    endtask

    // Watch every transaction at the clock edge
    always @(posedge aclk) begin : watch
        column_outcome_t got;
        column_outcome_t want;
        if (!aresetn) begin
            library_size  = 0;
            rows_in       = 0;
            gap_in_column = 1'b0;
            keep_gapped   = 1'b1;
            predicted_outcomes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.slot   = m_tdata[spdc_pkg::IDX_OUT_W-1:0];
                got.count  = m_tdata[spdc_pkg::IDX_OUT_W +: spdc_pkg::COUNT_OUT_W];
                got.total  = m_tdata[spdc_pkg::IDX_OUT_W+spdc_pkg::COUNT_OUT_W +:
                                     spdc_pkg::TOTAL_OUT_W];
                got.status = spdc_pkg::col_status_t'(m_tuser[1:0]);
                if (predicted_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected column result %0s %0d %0s %0d %0s %0d %0s %0d",
                                 $realtime, "slot", got.slot, "status", got.status,
                                 "count", got.count, "total", got.total);
                end else begin
                    want = predicted_outcomes.pop_front();
                    if (got.slot != want.slot || got.status != want.status ||
                        got.count != want.count || got.total != want.total) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: column mismatch exp slot %0d status %0d %0s %0d %0s %0d",
                                     $realtime, want.slot, want.status,
                                     "count", want.count, "total", want.total,
                                     "\n    got slot %0d status %0d count %0d total %0d",
                                     got.slot, got.status, got.count, got.total);
                    end
                end
            end
            if (cfg_wr_en)
                keep_gapped = cfg_wr_data;
            if (s_tvalid && s_tready)
                fold_row(s_tdata[spdc_pkg::SYMBOL_W-1:0], s_tlast);
        end
        failures     <= mismatch_count;
        columns_open <= predicted_outcomes.size();
    end

endmodule

/* test/site_pattern_dedup_counter_top_tb.sv */
// Testbench top for the site pattern dedup counter: clock, reset, row stimulus,
// config writes and verdict. Depends on spdc_pkg, the block and spdc_column_checker.
module site_pattern_dedup_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS     = 32;
    localparam int MAX_PATTERNS = 64;
    localparam int COUNT_BITS   = 24;
    localparam int LONGEST      = 40;     // longest random column
    localparam int SAVED        = 32;     // columns kept for repeats
    localparam int RANDOM_ROWS  = 1630;
    localparam int SEGMENTS     = 16;
    localparam int QUIET_LIMIT  = 20000;  // well above a full-table scan of long patterns
    localparam int SETTLE_WAIT  = 16;
    localparam int TAIL_WAIT    = 200;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic                             cfg_wr_data = 1'b0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [spdc_pkg::S_TDATA_W-1:0]   s_tdata     = '0;
    logic                             s_tlast     = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [spdc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [spdc_pkg::M_TUSER_W-1:0]   m_tuser;

    int unsigned            failures;
    int unsigned            columns_open;
    int unsigned            quiet_cycles = 0;
    int                     idle_pct     = 0;
    int                     stall_pct    = 0;
    int unsigned            rows_sent    = 0;

    logic [spdc_pkg::SYMBOL_W-1:0] pending_rows[$];
    logic [spdc_pkg::SYMBOL_W-1:0] saved_rows [SAVED][LONGEST];
    int                     saved_len [SAVED];
    int                     saved_count  = 0;
    int                     saved_next   = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    site_pattern_dedup_counter_top #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_PATTERNS(MAX_PATTERNS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    spdc_column_checker #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_PATTERNS(MAX_PATTERNS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .failures    (failures),
        .columns_open(columns_open)
    );

    // Result backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Cycles since the last transaction on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("FAIL site_pattern_dedup_counter_top");
        $finish;
    end

    // One row transaction, with random idle cycles ahead of it
    task automatic send_row(input logic [spdc_pkg::SYMBOL_W-1:0] sym, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(spdc_pkg::S_TDATA_W-spdc_pkg::SYMBOL_W){1'b0}}, sym};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        rows_sent++;
    endtask

    task automatic send_column();
        int r;
        for (r = 0; r < pending_rows.size(); r++)
            send_row(pending_rows[r], r == pending_rows.size() - 1);
    endtask

    // Stop sending and wait until every column result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (columns_open != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_keep(input logic keep);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= keep;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random column: half repeats of earlier columns, half fresh ones
    task automatic build_column();
        int pick;
        int n;
        int h;
        int r;
        pending_rows.delete();
        pick = $urandom_range(99);
        if (saved_count != 0 && pick < 50) begin
            h = $urandom_range(saved_count - 1);
            n = saved_len[h];
            for (r = 0; r < n; r++)
                pending_rows.push_back(saved_rows[h][r]);
            // rows past the table depth may differ and still match
            if (n > MAX_ROWS && $urandom_range(1) == 1)
                for (r = MAX_ROWS; r < n; r++)
                    pending_rows[r] = spdc_pkg::SYMBOL_W'($urandom_range(15));
        end else begin
            if (pick < 54)
                n = $urandom_range(MAX_ROWS + 1, LONGEST);
            else if (pick < 58)
                n = MAX_ROWS;
            else if (pick < 68)
                n = $urandom_range(5, 12);
            else
                n = $urandom_range(1, 4);
            h = saved_next;
            for (r = 0; r < n; r++) begin
                pending_rows.push_back(spdc_pkg::SYMBOL_W'($urandom_range(15)));
                saved_rows[h][r] = pending_rows[r];
            end
            saved_len[h] = n;
            saved_next   = (saved_next + 1) % SAVED;
            if (saved_count < SAVED)
                saved_count++;
        end
    endtask

    initial begin
        int seg;
        int unsigned directed_rows;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: gaps kept after reset
        pending_rows = '{4'd0};                     send_column();  // new, single row
        pending_rows = '{4'd0};                     send_column();  // match
        pending_rows = '{4'd15, 4'd15};             send_column();  // new
        pending_rows = '{4'd0, 4'd0};               send_column();  // same rows, longer
        pending_rows = '{spdc_pkg::GAP_CODE};       send_column();  // gapped, kept
        settle();
        write_keep(1'b0);
        pending_rows = '{spdc_pkg::GAP_CODE};       send_column();  // dropped though stored
        pending_rows = '{4'd1, 4'd2, spdc_pkg::GAP_CODE};
        send_column();  // gap in last row
        pending_rows = '{spdc_pkg::GAP_CODE, 4'd3, 4'd3};
        send_column();  // gap in first row
        pending_rows = '{4'd15, 4'd15};             send_column();  // match
        settle();
        write_keep(1'b1);
        pending_rows = '{spdc_pkg::GAP_CODE};       send_column();  // match again
        pending_rows = '{4'd8, 4'd7, 4'd6, 4'd5, 4'd3}; send_column();
        directed_rows = rows_sent;

        // Random: four pacing modes, config toggled between segments
        for (seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            write_keep(seg % 2 == 1);
            case (seg / 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            while (rows_sent < directed_rows + RANDOM_ROWS * (seg + 1) / SEGMENTS) begin
                build_column();
                send_column();
            end
        end

        settle();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (failures == 0 && columns_open == 0)
            $display("PASS site_pattern_dedup_counter_top");
        else
            $display("FAIL site_pattern_dedup_counter_top");
        $finish;
    end

endmodule
